FILE: src/max_heap_priority_queue_defines.svh
// Assertion helpers for the checker that verifies the heap queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MHPQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MHPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mhpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] key_value;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_key;
    logic [7:0]         entry_count;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_RM_TOP,
    ST_RM_LAST,
    ST_DN_LEFT,
    ST_DN_RIGHT,
    ST_PLACE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: src/max_heap_priority_queue.sv
// Binary max-heap priority queue, one operation in flight at a time.
// Insert: the new key climbs past each smaller parent toward the root, then is
// placed. Remove: the root key is read, the last key is read and sifted down past
// each larger child, then placed; an error goes straight to the response. The
// next request word is taken only once the queue is back in idle.
// Reset clears the key count and control; the key store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int HEAP_DEPTH = 256,
  parameter int KEY_WIDTH  = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_word_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_word_t      rsp
);

  localparam int AW = $clog2(HEAP_DEPTH);

  state_t state, state_next;

  logic [AW-1:0]        count, count_next;
  logic [AW-1:0]        up, up_next;
  logic [AW:0]          down, down_next;
  logic [KEY_WIDTH-1:0] hold, hold_next;
  logic [KEY_WIDTH-1:0] left, left_next;
  logic [1:0]           res_status, res_status_next;
  logic [31:0]          res_key, res_key_next;
  logic                 load_rsp;

  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [KEY_WIDTH-1:0] rd_data, wr_data;

  logic [KEY_WIDTH-1:0] cmp_key;
  logic [AW-1:0]        cmp_idx;
  logic [AW:0]          cmp_down;
  logic [AW:0]          n_ext;

  mhpq_store #(
    .DEPTH(HEAP_DEPTH),
    .WIDTH(KEY_WIDTH),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign req_stall = (state != ST_IDLE);
  assign n_ext     = {1'b0, count};

  // Larger child for the sift-down step; the left child wins a tie.
  always_comb begin
    if (state == ST_DN_RIGHT && $signed(left) < $signed(rd_data)) begin
      cmp_key = rd_data;
      cmp_idx = down[AW-1:0] + AW'(1);
    end else if (state == ST_DN_RIGHT) begin
      cmp_key = left;
      cmp_idx = down[AW-1:0];
    end else begin
      cmp_key = rd_data;
      cmp_idx = down[AW-1:0];
    end
    cmp_down = {cmp_idx, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    up         <= up_next;
    down       <= down_next;
    hold       <= hold_next;
    left       <= left_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    if (load_rsp) begin
      rsp.status      <= res_status;
      rsp.removed_key <= res_key;
      rsp.entry_count <= 8'(count);
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    up_next         = up;
    down_next       = down;
    hold_next       = hold;
    left_next       = left;
    res_status_next = res_status;
    res_key_next    = res_key;
    load_rsp        = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = up;
    wr_data         = hold;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          res_key_next    = '0;
          res_status_next = STATUS_DONE;
          if (req.operation == OP_INSERT) begin
            if (count == AW'(HEAP_DEPTH - 1)) begin
              res_status_next = STATUS_FULL;
              state_next      = ST_DONE;
            end else begin
              hold_next  = KEY_WIDTH'($signed(req.key_value));
              count_next = count + AW'(1);
              up_next    = count + AW'(1);
              if (count == '0) begin
                state_next = ST_PLACE;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = (count + AW'(1)) >> 1;
                state_next = ST_UP;
              end
            end
          end else begin
            if (count == '0) begin
              res_status_next = STATUS_EMPTY;
              state_next      = ST_DONE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = AW'(1);
              state_next = ST_RM_TOP;
            end
          end
        end
      end

      // The parent of slot up is on the read data.
      ST_UP: begin
        if ($signed(hold) > $signed(rd_data)) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          up_next = up >> 1;
          if ((up >> 1) == AW'(1)) begin
            state_next = ST_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = up >> 2;
          end
        end else begin
          state_next = ST_PLACE;
        end
      end

      ST_RM_TOP: begin
        res_key_next = 32'($signed(rd_data));
        rd_en        = 1'b1;
        rd_addr      = count;
        count_next   = count - AW'(1);
        state_next   = ST_RM_LAST;
      end

      ST_RM_LAST: begin
        hold_next = rd_data;
        up_next   = AW'(1);
        down_next = (AW + 1)'(2);
        if ((AW + 1)'(2) <= n_ext) begin
          rd_en      = 1'b1;
          rd_addr    = AW'(2);
          state_next = ST_DN_LEFT;
        end else begin
          state_next = ST_PLACE;
        end
      end

      ST_DN_LEFT, ST_DN_RIGHT: begin
        if (state == ST_DN_LEFT && down < n_ext) begin
          left_next  = rd_data;
          rd_en      = 1'b1;
          rd_addr    = down[AW-1:0] + AW'(1);
          state_next = ST_DN_RIGHT;
        end else if ($signed(hold) >= $signed(cmp_key)) begin
          state_next = ST_PLACE;
        end else begin
          wr_en     = 1'b1;
          wr_data   = cmp_key;
          up_next   = cmp_idx;
          down_next = cmp_down;
          if (cmp_down <= n_ext) begin
            rd_en      = 1'b1;
            rd_addr    = cmp_down[AW-1:0];
            state_next = ST_DN_LEFT;
          end else begin
            state_next = ST_PLACE;
          end
        end
      end

      ST_PLACE: begin
        wr_en      = 1'b1;
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/mhpq_store.sv
`timescale 1ns / 1ps
`default_nettype none

module mhpq_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/mhpq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "max_heap_priority_queue_defines.svh"

module mhpq_checker
  import mhpq_pkg::*;
#(
  parameter int HEAP_DEPTH = 256
) (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      req_valid,
  input wire logic      req_stall,
  input wire req_word_t req,
  input wire logic      rsp_valid,
  input wire logic      rsp_stall,
  input wire rsp_word_t rsp
);

  localparam logic [7:0] FULL_COUNT = 8'(HEAP_DEPTH - 1);

  `MHPQ_ASSERT_NEXT(a_rsp_valid_holds, clk, rst, rsp_valid && rsp_stall, rsp_valid,
    "response word dropped while stalled")

  `MHPQ_ASSERT_NEXT(a_rsp_word_holds, clk, rst, rsp_valid && rsp_stall, $stable(rsp),
    "response word changed while stalled")

  `MHPQ_ASSERT_IMPLY(a_error_no_key, clk, rst,
    rsp_valid && rsp.status != STATUS_DONE, rsp.removed_key == 32'sd0,
    "error response carries a key")

  `MHPQ_ASSERT_IMPLY(a_empty_count, clk, rst,
    rsp_valid && rsp.status == STATUS_EMPTY, rsp.entry_count == 8'd0,
    "empty error with keys held")

  `MHPQ_ASSERT_IMPLY(a_full_count, clk, rst,
    rsp_valid && rsp.status == STATUS_FULL, rsp.entry_count == FULL_COUNT,
    "full error below capacity")

endmodule

bind max_heap_priority_queue mhpq_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);

`default_nettype wire
